FILE: rtl/dts_pkg.sv
package dts_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_MODIFY = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DELETED = 2'd1,
        ST_ALREADY = 2'd2,
        ST_PAST    = 2'd3
    } status_t;

    localparam int MAX_FIRE = 16;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  timer_id;
        logic [31:0] expires;
        logic [31:0] now;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired_valid;
        logic [3:0]  fired_id;
        logic [31:0] fired_expires;
        logic        last;
        logic        deadline_valid;
        logic [31:0] deadline;
    } res_item_t;

    // classified command handed from front to back
    typedef struct packed {
        cmd_op_t     op;
        logic        in_range;
        logic [3:0]  timer_id;
        logic [31:0] expires;
        logic [31:0] now;
    } cmd_t;

    // one buffered result, before the deadline is attached
    typedef struct packed {
        status_t     status;
        logic        fired_valid;
        logic [3:0]  fired_id;
        logic [31:0] fired_expires;
    } fire_ent_t;

endpackage

FILE: rtl/dts_ram.sv
module dts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: rtl/dts_front.sv
module dts_front
    import dts_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  req_item_t request,
    output logic      full,
    output logic      head_valid,
    output cmd_t      head,
    input  logic      take
);

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    cmd_t       cls;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rp_reg];
    assign do_push    = push && !full;

    // classify: decode the command and check the slot range
    always_comb
    begin
        cls.op       = cmd_op_t'(request.command);
        cls.in_range = ({28'd0, request.timer_id} < 32'(SLOTS));
        cls.timer_id = request.timer_id;
        cls.expires  = request.expires;
        cls.now      = request.now;
    end

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = !wp_reg;
        end
        if (take && head_valid)
        begin
            rp_next = !rp_reg;
        end
        case ({do_push, take && head_valid})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/dts_back.sv
module dts_back
    import dts_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head,
    output logic      take,
    output logic      res_valid,
    output res_item_t result,
    input  logic      pop
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TB = TIME_BITS;
    localparam int RW = TB + 16;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [SLOTS-1:0] pend_reg, pend_next;
    logic [15:0]      stamp_cnt_reg, stamp_cnt_next;
    cmd_t             cmd_reg, cmd_next;
    logic             fire_mode_reg, fire_mode_next;
    logic [CW-1:0]    sc_reg, sc_next;
    logic             rd_v_reg, rd_v_next;
    logic [IW-1:0]    rd_idx_reg, rd_idx_next;
    logic             best_v_reg, best_v_next;
    logic [TB-1:0]    best_key_reg, best_key_next;
    logic [15:0]      best_age_reg, best_age_next;
    logic [IW-1:0]    best_idx_reg, best_idx_next;
    logic [TB-1:0]    best_exp_reg, best_exp_next;
    logic [4:0]       res_cnt_reg, res_cnt_next;
    logic [3:0]       rd_ptr_reg, rd_ptr_next;
    logic             dl_v_reg, dl_v_next;
    logic [31:0]      dl_reg, dl_next;

    fire_ent_t        res_mem_reg [MAX_FIRE];
    logic             res_we;
    fire_ent_t        res_wdata;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [RW-1:0]    ram_wdata;
    logic [IW-1:0]    ram_raddr;
    logic [RW-1:0]    ram_rdata;

    logic [IW-1:0]    sid;
    logic [TB-1:0]    exp_t;
    logic [TB-1:0]    now_t;
    logic [TB-1:0]    stored_exp;
    logic [TB-1:0]    exp_dist;
    logic [TB-1:0]    rd_dist;
    logic [TB-1:0]    rd_key;
    logic [15:0]      rd_age;
    logic [TB-1:0]    best_dist;
    logic             best_expired;
    logic [63:0]      best_exp_wide;

    dts_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sid           = IW'(cmd_reg.timer_id);
    assign exp_t         = TB'(cmd_reg.expires);
    assign now_t         = TB'(cmd_reg.now);
    assign stored_exp    = ram_rdata[RW-1:16];
    assign exp_dist      = exp_t - now_t;
    assign rd_dist       = stored_exp - now_t;
    assign rd_key        = {~rd_dist[TB-1], rd_dist[TB-2:0]};
    assign rd_age        = stamp_cnt_reg - ram_rdata[15:0];
    assign best_dist     = best_exp_reg - now_t;
    assign best_expired  = (best_dist == '0) || best_dist[TB-1];
    assign best_exp_wide = 64'(best_exp_reg);

    assign res_valid             = (state_reg == S_EMIT);
    assign result.status         = res_mem_reg[rd_ptr_reg].status;
    assign result.fired_valid    = res_mem_reg[rd_ptr_reg].fired_valid;
    assign result.fired_id       = res_mem_reg[rd_ptr_reg].fired_id;
    assign result.fired_expires  = res_mem_reg[rd_ptr_reg].fired_expires;
    assign result.last           = ((5'(rd_ptr_reg) + 5'd1) == res_cnt_reg);
    assign result.deadline_valid = dl_v_reg;
    assign result.deadline       = dl_reg;

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        stamp_cnt_next = stamp_cnt_reg;
        cmd_next       = cmd_reg;
        fire_mode_next = fire_mode_reg;
        sc_next        = sc_reg;
        rd_v_next      = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_v_next    = best_v_reg;
        best_key_next  = best_key_reg;
        best_age_next  = best_age_reg;
        best_idx_next  = best_idx_reg;
        best_exp_next  = best_exp_reg;
        res_cnt_next   = res_cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        dl_v_next      = dl_v_reg;
        dl_next        = dl_reg;
        take           = 1'b0;
        res_we         = 1'b0;
        res_wdata      = '{status: ST_DONE, fired_valid: 1'b0, fired_id: 4'd0,
                           fired_expires: 32'd0};
        ram_we         = 1'b0;
        ram_waddr      = sid;
        ram_wdata      = {exp_t, stamp_cnt_reg};
        ram_raddr      = IW'(head.timer_id);

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    take           = 1'b1;
                    cmd_next       = head;
                    res_cnt_next   = 5'd0;
                    rd_ptr_next    = 4'd0;
                    fire_mode_next = (head.op == CMD_TICK);
                    if (head.op == CMD_TICK)
                    begin
                        sc_next     = '0;
                        best_v_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_CMD;
                    end
                end
            end

            S_CMD:
            begin
                if (cmd_reg.in_range)
                begin
                    if (cmd_reg.op == CMD_DELETE)
                    begin
                        res_wdata.status = pend_reg[sid] ? ST_DELETED : ST_DONE;
                        pend_next[sid]   = 1'b0;
                    end
                    else if (cmd_reg.op == CMD_ADD && pend_reg[sid])
                    begin
                        res_wdata.status = ST_ALREADY;
                    end
                    else if (!(pend_reg[sid] && stored_exp == exp_t))
                    begin
                        ram_we = 1'b1;
                        if (exp_dist[TB-1])
                        begin
                            pend_next[sid]   = 1'b0;
                            res_wdata.status = ST_PAST;
                        end
                        else
                        begin
                            pend_next[sid] = 1'b1;
                            stamp_cnt_next = stamp_cnt_reg + 16'd1;
                        end
                    end
                end
                res_we       = 1'b1;
                res_cnt_next = 5'd1;
                sc_next      = '0;
                best_v_next  = 1'b0;
                state_next   = S_SCAN;
            end

            S_SCAN:
            begin
                // issue one slot read a cycle, compare the slot read last cycle
                if (sc_reg < CW'(SLOTS))
                begin
                    ram_raddr   = sc_reg[IW-1:0];
                    sc_next     = sc_reg + CW'(1);
                    rd_v_next   = 1'b1;
                    rd_idx_next = sc_reg[IW-1:0];
                end
                if (rd_v_reg && pend_reg[rd_idx_reg])
                begin
                    if (!best_v_reg || rd_key < best_key_reg ||
                        (rd_key == best_key_reg && rd_age > best_age_reg))
                    begin
                        best_v_next   = 1'b1;
                        best_key_next = rd_key;
                        best_age_next = rd_age;
                        best_idx_next = rd_idx_reg;
                        best_exp_next = stored_exp;
                    end
                end
                if (sc_reg == CW'(SLOTS) && !rd_v_reg)
                begin
                    if (fire_mode_reg && best_v_reg && best_expired &&
                        res_cnt_reg < 5'(MAX_FIRE))
                    begin
                        pend_next[best_idx_reg]   = 1'b0;
                        res_we                    = 1'b1;
                        res_wdata.fired_valid     = 1'b1;
                        res_wdata.fired_id        = 4'(best_idx_reg);
                        res_wdata.fired_expires   = best_exp_wide[31:0];
                        res_cnt_next              = res_cnt_reg + 5'd1;
                        sc_next                   = '0;
                        best_v_next               = 1'b0;
                    end
                    else
                    begin
                        dl_v_next = best_v_reg;
                        dl_next   = best_v_reg ? best_exp_wide[31:0] : 32'd0;
                        if (fire_mode_reg && res_cnt_reg == 5'd0)
                        begin
                            res_we       = 1'b1;
                            res_cnt_next = 5'd1;
                        end
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (pop)
                begin
                    if (result.last)
                    begin
                        rd_ptr_next = 4'd0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 4'd1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem_reg[res_cnt_reg[3:0]] <= res_wdata;
        end
        cmd_reg       <= cmd_next;
        rd_idx_reg    <= rd_idx_next;
        best_key_reg  <= best_key_next;
        best_age_reg  <= best_age_next;
        best_idx_reg  <= best_idx_next;
        best_exp_reg  <= best_exp_next;
        dl_reg        <= dl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= '0;
            stamp_cnt_reg <= 16'd0;
            fire_mode_reg <= 1'b0;
            sc_reg        <= '0;
            rd_v_reg      <= 1'b0;
            best_v_reg    <= 1'b0;
            res_cnt_reg   <= 5'd0;
            rd_ptr_reg    <= 4'd0;
            dl_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            stamp_cnt_reg <= stamp_cnt_next;
            fire_mode_reg <= fire_mode_next;
            sc_reg        <= sc_next;
            rd_v_reg      <= rd_v_next;
            best_v_reg    <= best_v_next;
            res_cnt_reg   <= res_cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            dl_v_reg      <= dl_v_next;
        end
    end

endmodule

FILE: rtl/deadline_timer_set.sv
// Deadline timer set: SLOTS one-shot timers driven by add, modify, delete
// and tick commands pushed into a two-item input queue. Each command is
// answered by one result; a tick answers with one result per fired timer
// (up to 16, earliest first, equal expiries in insertion order) or with a
// single empty result when nothing is due. Every result carries the
// earliest deadline still pending after the command. Results of one
// command appear only once the whole command is done, and the next
// command starts only after they have all been popped. Every minimum
// search walks the slot RAM one slot per cycle, then makes the last
// compare and then the decision.
module deadline_timer_set
    import dts_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  req_item_t request,
    output logic      full,
    output logic      empty,
    output res_item_t result,
    input  logic      pop
);

    logic head_valid;
    cmd_t head;
    logic take;
    logic res_valid;

    // front: queue and classify incoming items
    dts_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .request    (request),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .take       (take)
    );

    // back: carry out commands against the slot store, buffer results
    dts_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .take       (take),
        .res_valid  (res_valid),
        .result     (result),
        .pop        (pop)
    );

    assign empty = !res_valid;

`ifndef ASSERT_OFF
    // a fired item always reports plain completion
    a_fire_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.fired_valid) |-> (result.status == ST_DONE))
        else $error("fired item with nonzero status");

    // more items of the same command follow right after a non-final pop
    a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last) |=> !empty)
        else $error("result burst broken before last item");

    // no deadline value without a pending timer
    a_deadline_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.deadline_valid) |-> (result.deadline == 32'd0))
        else $error("deadline set while no timer pending");

    // no new command is taken while results wait
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !take)
        else $error("command taken while results pending");
`endif

endmodule

FILE: verif/tb_deadline_timer_set.sv
`timescale 1ns / 100ps

module tb_deadline_timer_set;
    import dts_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      push;
    req_item_t request;
    logic      full;
    logic      empty;
    res_item_t result;
    logic      pop;

    deadline_timer_set dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .request (request),
        .full    (full),
        .empty   (empty),
        .result  (result),
        .pop     (pop)
    );

    // Clock: 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Shadow copy of the timer slots, updated as each item is accepted.
    logic        timer_armed [16];
    logic [31:0] timer_expiry [16];
    logic [15:0] timer_stamp [16];
    logic [15:0] next_stamp;

    res_item_t expected_results [$];
    int        mismatches;
    int        results_seen;
    int        fires_seen;
    bit        allow_idle;
    bit        hold_pop;
    int        hold_cycles;

    // Order key: signed distance from now, flipped so unsigned compare works.
    function automatic logic [31:0] order_key(logic [31:0] t, logic [31:0] now);
        logic [31:0] d;
        begin
            d = t - now;
            order_key = d ^ 32'h8000_0000;
        end
    endfunction

    function automatic int earliest_slot(logic [31:0] now);
        int          best;
        logic [31:0] bkey;
        logic [31:0] k;
        logic [15:0] bage;
        logic [15:0] age;
        begin
            best = -1;
            bkey = '0;
            bage = '0;
            for (int i = 0; i < 16; i++)
            begin
                if (timer_armed[i])
                begin
                    k   = order_key(timer_expiry[i], now);
                    age = next_stamp - timer_stamp[i];
                    if (best < 0 || k < bkey || (k == bkey && age > bage))
                    begin
                        best = i;
                        bkey = k;
                        bage = age;
                    end
                end
            end
            earliest_slot = best;
        end
    endfunction

    // Apply one command to the shadow timers and queue its results.
    task automatic predict_timers(req_item_t req);
        res_item_t   batch [$];
        res_item_t   r;
        int          best;
        int          s;
        logic [31:0] t;
        logic [31:0] d;
        logic [1:0]  st;
        begin
            if (cmd_op_t'(req.command) == CMD_TICK)
            begin
                while (batch.size() < MAX_FIRE)
                begin
                    best = earliest_slot(req.now);
                    if (best < 0)
                        break;
                    t = timer_expiry[best];
                    d = t - req.now;
                    if (!(t == req.now || d[31]))
                        break;
                    timer_armed[best] = 1'b0;
                    r = '0;
                    r.status        = ST_DONE;
                    r.fired_valid   = 1'b1;
                    r.fired_id      = best[3:0];
                    r.fired_expires = t;
                    batch.push_back(r);
                end
                if (batch.size() == 0)
                begin
                    r = '0;
                    batch.push_back(r);
                end
            end
            else
            begin
                s  = req.timer_id;
                st = ST_DONE;
                d  = req.expires - req.now;
                if (cmd_op_t'(req.command) == CMD_DELETE)
                begin
                    st = timer_armed[s] ? ST_DELETED : ST_DONE;
                    timer_armed[s] = 1'b0;
                end
                else if (cmd_op_t'(req.command) == CMD_ADD && timer_armed[s])
                    st = ST_ALREADY;
                else if (!(timer_armed[s] && timer_expiry[s] == req.expires))
                begin
                    timer_armed[s]  = 1'b0;
                    timer_expiry[s] = req.expires;
                    if (d[31])
                        st = ST_PAST;
                    else
                    begin
                        timer_stamp[s] = next_stamp;
                        next_stamp     = next_stamp + 16'd1;
                        timer_armed[s] = 1'b1;
                    end
                end
                r = '0;
                r.status = st;
                batch.push_back(r);
            end
            best = earliest_slot(req.now);
            foreach (batch[k])
            begin
                batch[k].last           = (k == batch.size() - 1);
                batch[k].deadline_valid = (best >= 0);
                batch[k].deadline       = (best >= 0) ? timer_expiry[best] : '0;
                expected_results.push_back(batch[k]);
            end
        end
    endtask

    // Send one item; idle a random burst first when allowed.
    // Push stays high between back-to-back items; drop it only to idle.
    task automatic send_item(cmd_op_t op, logic [3:0] id, logic [31:0] exp_t,
                             logic [31:0] now);
        req_item_t req;
        begin
            if (allow_idle && $urandom_range(0, 3) == 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            req.command  = op;
            req.timer_id = id;
            req.expires  = exp_t;
            req.now      = now;
            push    <= 1'b1;
            request <= req;
            do
                @(posedge clk);
            while (full);
            predict_timers(req);
        end
    endtask

    // Drop push and hold the sender until every expected result has been popped.
    task automatic drain_results();
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while (expected_results.size() != 0);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_pop && hold_cycles < 400)
            begin
                hold_cycles++;
                pop <= 1'b0;
            end
            else if (allow_idle && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                pop <= 1'b1;
            end
            else
                pop <= 1'b1;
        end
    end

    // Checker: compare each popped item with the oldest expectation.
    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (result.fired_valid)
                fires_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, result);
                end
            end
        end
    end

    // Corners: extreme ids and times, each status code, equal-time ties.
    task automatic test_directed();
        begin
            send_item(CMD_TICK, 4'd0, 32'd0, 32'd0);
            send_item(CMD_ADD, 4'd0, 32'd100, 32'd0);
            send_item(CMD_ADD, 4'd0, 32'd200, 32'd0);
            send_item(CMD_ADD, 4'd15, 32'd100, 32'd0);
            send_item(CMD_ADD, 4'd7, 32'd100, 32'd0);
            send_item(CMD_MODIFY, 4'd0, 32'd100, 32'd10);
            send_item(CMD_MODIFY, 4'd0, 32'd100, 32'd10);
            send_item(CMD_MODIFY, 4'd3, 32'd5, 32'd10);
            send_item(CMD_ADD, 4'd4, 32'hFFFF_FFFF, 32'd20);
            send_item(CMD_ADD, 4'd5, 32'h7FFF_FFFF, 32'h0);
            send_item(CMD_TICK, 4'd9, 32'hFFFF_FFFF, 32'd99);
            send_item(CMD_TICK, 4'd0, 32'd0, 32'd100);
            send_item(CMD_DELETE, 4'd4, 32'd0, 32'd100);
            send_item(CMD_DELETE, 4'd4, 32'hFFFF_FFFF, 32'd100);
            send_item(CMD_ADD, 4'd1, 32'd2, 32'hFFFF_FFF0);
            send_item(CMD_ADD, 4'd2, 32'hFFFF_FFF8, 32'hFFFF_FFF0);
            send_item(CMD_TICK, 4'd0, 32'd0, 32'd3);
            send_item(CMD_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);
            drain_results();
        end
    endtask

    // Fill all sixteen slots, then sweep: a full 16-fire tick.
    task automatic test_full_sweep();
        logic [31:0] base;
        begin
            base = $urandom;
            for (int i = 0; i < 16; i++)
                send_item(CMD_ADD, i[3:0], base + $urandom_range(0, 3), base);
            send_item(CMD_TICK, 4'd0, 32'd0, base + 32'd3);
            drain_results();
        end
    endtask

    // Stall the receiver for a long stretch while items keep coming.
    task automatic test_backpressure();
        begin
            hold_cycles = 0;
            hold_pop    = 1'b1;
            for (int i = 0; i < 12; i++)
                send_item(cmd_op_t'($urandom_range(0, 3)), 4'($urandom),
                          32'd1000 + $urandom_range(0, 50), 32'd1000);
            hold_pop = 1'b0;
            drain_results();
        end
    endtask

    // Mostly arm-then-sweep traffic around a drifting clock, some noise.
    task automatic test_random(int count);
        logic [31:0] now;
        cmd_op_t     op;
        begin
            now = $urandom;
            for (int i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(cmd_op_t'($urandom_range(0, 3)), 4'($urandom),
                              $urandom, $urandom);
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: op = CMD_ADD;
                        4, 5:       op = CMD_MODIFY;
                        6:          op = CMD_DELETE;
                        default:    op = CMD_TICK;
                    endcase
                    if (op == CMD_TICK)
                        now = now + $urandom_range(0, 40);
                    send_item(op, 4'($urandom),
                              now + $urandom_range(0, 60) - 32'd5, now);
                end
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        request     = '0;
        allow_idle  = 1'b1;
        hold_pop    = 1'b0;
        hold_cycles = 0;
        mismatches  = 0;
        results_seen = 0;
        fires_seen  = 0;
        next_stamp  = '0;
        for (int i = 0; i < 16; i++)
        begin
            timer_armed[i]  = 1'b0;
            timer_expiry[i] = '0;
            timer_stamp[i]  = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_sweep();
        test_backpressure();
        test_random(200);
        drain_results();
        // last part runs at full rate on both sides
        allow_idle = 1'b0;
        test_full_sweep();
        test_random(60);
        drain_results();
        repeat (50) @(posedge clk);

        $display("covered add/modify/delete/tick, wrapped times and ties;");
        $display("%0d results checked, %0d timer fires", results_seen, fires_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: generous bound on the whole run.
    initial
    begin
        #20ms;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
